/* sv/upi_pkg.sv */
// Shared constants, tables and types of the unicycle pose integrator.
package upi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int IW               = $clog2(TABLE_LEN);
    localparam int CW               = 34;
    localparam int MW               = 33;
    localparam int PW               = 2 * MW;

    localparam logic signed [CW-1:0] INV_GAIN = 34'sh026DD3B6A;

    localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    localparam logic [7:0] CFG_STEP_TIME     = 8'd0;
    localparam logic [7:0] CFG_GOAL_X        = 8'd1;
    localparam logic [7:0] CFG_GOAL_Y        = 8'd2;
    localparam logic [7:0] CFG_ARRIVE_RADIUS = 8'd3;

    typedef struct packed {
        logic start;
    } t_cord_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cord_st;

endpackage

/* sv/upi_mul.sv */
// Shared signed multiplier with registered product.
module upi_mul (
    input  logic                          i_clk,
    input  logic signed [upi_pkg::MW-1:0] i_a,
    input  logic signed [upi_pkg::MW-1:0] i_b,
    output logic signed [upi_pkg::PW-1:0] o_p
);

    logic signed [upi_pkg::PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* sv/upi_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle through a shared add and shift unit.
module upi_cordic #(
    parameter int STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  upi_pkg::t_cord_ctl            i_ctl,
    input  logic [15:0]                   i_angle,
    output upi_pkg::t_cord_st             o_st,
    output logic signed [upi_pkg::CW-1:0] o_cos,
    output logic signed [upi_pkg::CW-1:0] o_sin
);

    localparam int NSTEPS = (STEPS < upi_pkg::TABLE_LEN) ? STEPS : upi_pkg::TABLE_LEN;
    localparam logic [upi_pkg::IW-1:0] LAST = upi_pkg::IW'(NSTEPS - 1);

    logic signed [upi_pkg::CW-1:0] r_x;
    logic signed [upi_pkg::CW-1:0] r_y;
    logic signed [upi_pkg::CW-1:0] r_z;
    logic [upi_pkg::IW-1:0]        r_idx;
    logic                          r_busy;
    logic                          r_done;

    logic                          flip;
    logic [31:0]                   z_start;
    logic signed [upi_pkg::CW-1:0] xs;
    logic signed [upi_pkg::CW-1:0] ys;
    logic signed [upi_pkg::CW-1:0] at;

    assign flip    = i_angle[15] ^ i_angle[14];
    assign z_start = {i_angle, 16'h0000} ^ (flip ? 32'h8000_0000 : 32'h0000_0000);
    assign xs      = r_x >>> r_idx;
    assign ys      = r_y >>> r_idx;
    assign at      = $signed({2'b00, upi_pkg::ATAN_TABLE[r_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= flip ? -upi_pkg::INV_GAIN : upi_pkg::INV_GAIN;
            r_y <= '0;
            r_z <= $signed({{2{z_start[31]}}, z_start});
        end else if (r_busy) begin
            if (!r_z[upi_pkg::CW-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_cos     = r_x;
    assign o_sin     = r_y;

endmodule

/* sv/unicycle_pose_integrator.sv */
// Top level of the unicycle pose integrator: sequencer, pose and configuration registers.
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one item: a tick (action 0) with
//   linear velocity and turn rate, or a set-pose (action 1) with new x, y and heading.
//   Output channel (o_out_valid / i_out_stall) gives one item per input item: the pose
//   after the item and the arrived flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes step time, goal x, goal y
//   and arrive radius by index; it is always ready. The user must write it only while
//   idle; the block itself does not enforce this.
// Sequencing:
//   A tick runs the CORDIC iterations and up to seven passes through the shared multiplier.
//   A set-pose starts at S_LOAD; an item far from the goal skips S_AMX to S_ACMP.
//   One item is worked on at a time; o_in_stall is high from acceptance until the result
//   is placed in the output register, so the next item may enter while it waits.
// Reset and stall:
//   Reset clears the pose to zero and loads the register defaults (step time 1966).
//   A stalled result holds in the output register; the sequencer waits at its last
//   step until the register is free.
module unicycle_pose_integrator #(
    parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic signed [31:0] i_linear_velocity,
    input  logic signed [15:0] i_angular_rate,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [15:0] i_new_heading,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [15:0] o_out_heading,
    output logic               o_arrived,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int MW = upi_pkg::MW;
    localparam int PW = upi_pkg::PW;
    localparam int CW = upi_pkg::CW;

    typedef enum logic [12:0] {
        S_IDLE = 13'h0001,
        S_LOAD = 13'h0002,
        S_TMV  = 13'h0004,
        S_TMW  = 13'h0008,
        S_TANG = 13'h0010,
        S_CORD = 13'h0020,
        S_TMS  = 13'h0040,
        S_TUY  = 13'h0080,
        S_ARR  = 13'h0100,
        S_AMR  = 13'h0200,
        S_AMX  = 13'h0400,
        S_AMY  = 13'h0800,
        S_ACMP = 13'h1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [15:0]        r_step_time;
    logic signed [31:0] r_goal_x;
    logic signed [31:0] r_goal_y;
    logic [30:0]        r_radius;

    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic [15:0]        r_head;

    logic signed [31:0] r_v;
    logic signed [15:0] r_w;
    logic signed [31:0] r_nx;
    logic signed [31:0] r_ny;
    logic [15:0]        r_nh;
    logic signed [31:0] r_dist;
    logic [15:0]        r_turn;
    logic [31:0]        r_ax;
    logic [31:0]        r_ay;
    logic [63:0]        r_rr;
    logic [63:0]        r_sx;

    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic [15:0]        r_out_head;
    logic               r_out_arr;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    upi_pkg::t_cord_ctl   cord_ctl;
    upi_pkg::t_cord_st    cord_st;
    logic signed [CW-1:0] cord_cos;
    logic signed [CW-1:0] cord_sin;

    logic                 in_acc;
    logic                 out_free;
    logic                 out_wr;
    logic                 out_arr;
    logic signed [PW-1:0] p_rnd15;
    logic signed [PW-1:0] p_rnd16;
    logic signed [PW-1:0] p_rnd29;
    logic signed [PW-1:0] p_sh30;
    logic [15:0]          half_n;
    logic [15:0]          mid;
    logic signed [35:0]   step_d;
    logic signed [32:0]   dgx;
    logic signed [32:0]   dgy;
    logic                 far;
    logic [63:0]          sq_sum;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    upi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    upi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cord_ctl),
        .i_angle (mid),
        .o_st    (cord_st),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign p_rnd15 = prod + PW'(32768);
    assign p_rnd16 = prod + PW'(65536);
    assign p_rnd29 = prod + (PW'(1) <<< 29);
    assign p_sh30  = p_rnd29 >>> 30;
    assign half_n  = p_rnd16[32:17];
    assign mid     = r_head + half_n;
    assign step_d  = p_sh30[35:0];

    assign dgx    = {r_goal_x[31], r_goal_x} - {r_pos_x[31], r_pos_x};
    assign dgy    = {r_goal_y[31], r_goal_y} - {r_pos_y[31], r_pos_y};
    assign far    = (r_ax > {1'b0, r_radius}) || (r_ay > {1'b0, r_radius});
    assign sq_sum = r_sx + prod[63:0];

    assign cord_ctl.start = (r_state == S_TANG);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TMV: begin
                mul_a = {r_v[31], r_v};
                mul_b = $signed({17'd0, r_step_time});
            end
            S_TMW: begin
                mul_a = MW'(r_w);
                mul_b = $signed({17'd0, r_step_time});
            end
            S_CORD: begin
                mul_a = {r_dist[31], r_dist};
                mul_b = cord_cos[MW-1:0];
            end
            S_TMS: begin
                mul_a = {r_dist[31], r_dist};
                mul_b = cord_sin[MW-1:0];
            end
            S_AMR: begin
                mul_a = $signed({2'b00, r_radius});
                mul_b = $signed({2'b00, r_radius});
            end
            S_AMX: begin
                mul_a = $signed({1'b0, r_ax});
                mul_b = $signed({1'b0, r_ax});
            end
            S_AMY, S_ACMP: begin
                mul_a = $signed({1'b0, r_ay});
                mul_b = $signed({1'b0, r_ay});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        out_wr  = 1'b0;
        out_arr = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_action ? S_LOAD : S_TMV;
                end
            end
            S_LOAD: n_state = S_ARR;
            S_TMV:  n_state = S_TMW;
            S_TMW:  n_state = S_TANG;
            S_TANG: n_state = S_CORD;
            S_CORD: begin
                if (cord_st.done) begin
                    n_state = S_TMS;
                end
            end
            S_TMS:  n_state = S_TUY;
            S_TUY:  n_state = S_ARR;
            S_ARR:  n_state = S_AMR;
            S_AMR: begin
                if (!far) begin
                    n_state = S_AMX;
                end else if (out_free) begin
                    out_wr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_AMX:  n_state = S_AMY;
            S_AMY:  n_state = S_ACMP;
            S_ACMP: begin
                out_arr = (sq_sum <= r_rr);
                if (out_free) begin
                    out_wr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step_time <= 16'd1966;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_radius    <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_head      <= '0;
        end else begin
            r_state <= n_state;
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    upi_pkg::CFG_STEP_TIME:     r_step_time <= i_cfg_data[15:0];
                    upi_pkg::CFG_GOAL_X:        r_goal_x    <= $signed(i_cfg_data);
                    upi_pkg::CFG_GOAL_Y:        r_goal_y    <= $signed(i_cfg_data);
                    upi_pkg::CFG_ARRIVE_RADIUS: r_radius    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    r_pos_x <= r_nx;
                    r_pos_y <= r_ny;
                    r_head  <= r_nh;
                end
                S_TMS: r_pos_x <= sat32({{4{r_pos_x[31]}}, r_pos_x} + step_d);
                S_TUY: begin
                    r_pos_y <= sat32({{4{r_pos_y[31]}}, r_pos_y} + step_d);
                    r_head  <= r_head + r_turn;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_v  <= i_linear_velocity;
            r_w  <= i_angular_rate;
            r_nx <= i_new_x;
            r_ny <= i_new_y;
            r_nh <= i_new_heading;
        end
        case (r_state)
            S_TMW:  r_dist <= p_rnd15[47:16];
            S_TANG: r_turn <= p_rnd15[31:16];
            S_ARR: begin
                r_ax <= dgx[32] ? 32'(-dgx) : dgx[31:0];
                r_ay <= dgy[32] ? 32'(-dgy) : dgy[31:0];
            end
            S_AMX:  r_rr <= prod[63:0];
            S_AMY:  r_sx <= prod[63:0];
            default: ;
        endcase
        if (out_wr) begin
            r_out_x    <= r_pos_x;
            r_out_y    <= r_pos_y;
            r_out_head <= r_head;
            r_out_arr  <= out_arr;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_heading = r_out_head;
    assign o_arrived     = r_out_arr;
    assign o_cfg_ready   = 1'b1;

    a_accept_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOAD || r_state == S_TMV))
        else $error("accepted item did not start a load or a tick");

    a_cordic_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_st.busy |-> (r_state == S_CORD))
        else $error("CORDIC busy outside its sequencer step");

    a_load_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_pos_x == $past(r_nx) && r_head == $past(r_nh)))
        else $error("set-pose did not load the pose");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_wr |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented after the last step");

endmodule

/* test/unicycle_pose_integrator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the unicycle pose integrator, checked against a pose predictor.
module unicycle_pose_integrator_test;

    localparam logic ACT_TICK     = 1'b0;
    localparam logic ACT_SET_POSE = 1'b1;

    localparam logic [7:0] CFG_SPARE_FIRST = upi_pkg::CFG_ARRIVE_RADIUS + 8'd1;
    localparam logic [7:0] CFG_SPARE_LAST  = 8'hFF;

    localparam int TICK_LATENCY = upi_pkg::CORDIC_STEPS_DEF + 11;
    localparam int ONE_M        = 65536;
    localparam int NEAR_SPAN    = 32 * ONE_M;

    localparam logic signed [31:0] POS_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN     = 32'sh8000_0000;
    localparam logic signed [15:0] ANG_MAX     = 16'sh7FFF;
    localparam logic signed [15:0] ANG_MIN     = 16'sh8000;
    localparam logic signed [15:0] ANG_HALF_PI = 16'sh4000;
    localparam logic [15:0]        STEP_RESET  = 16'd1966;
    localparam longint             Q30_HALF    = 64'sd536870912;

    typedef struct {
        logic               action;
        logic signed [31:0] speed;
        logic signed [15:0] rate;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
    } t_motion_cmd;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic               arrived;
    } t_pose_result;

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic               i_action          = 1'b0;
    logic signed [31:0] i_linear_velocity = '0;
    logic signed [15:0] i_angular_rate    = '0;
    logic signed [31:0] i_new_x           = '0;
    logic signed [31:0] i_new_y           = '0;
    logic signed [15:0] i_new_heading     = '0;
    logic               i_out_stall       = 1'b0;
    logic               i_cfg_valid       = 1'b0;
    logic [7:0]         i_cfg_index       = '0;
    logic [31:0]        i_cfg_data        = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [15:0] o_out_heading;
    logic               o_arrived;
    logic               o_cfg_ready;

    // predicted configuration and pose
    logic [15:0]        step_time_q;
    logic signed [31:0] goal_x_q;
    logic signed [31:0] goal_y_q;
    logic [30:0]        radius_q;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_heading;

    t_pose_result pending_poses[$];

    bit idling       = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;

    int failures     = 0;
    int n_results    = 0;
    int n_ticks      = 0;
    int n_set_poses  = 0;
    int n_arrived    = 0;
    int n_clamped    = 0;
    int n_cfg_writes = 0;

    unicycle_pose_integrator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_linear_velocity (i_linear_velocity),
        .i_angular_rate    (i_angular_rate),
        .i_new_x           (i_new_x),
        .i_new_y           (i_new_y),
        .i_new_heading     (i_new_heading),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_out_heading     (o_out_heading),
        .o_arrived         (o_arrived),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(POS_MAX)) begin
            n_clamped++;
            return POS_MAX;
        end
        if (v < longint'(POS_MIN)) begin
            n_clamped++;
            return POS_MIN;
        end
        return v[31:0];
    endfunction

    function automatic void rotate_unit(input logic [15:0] ang, output longint c,
                                        output longint s);
        logic [31:0] z32;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        z32 = {ang, 16'h0000};
        x   = longint'(upi_pkg::INV_GAIN);
        y   = 0;
        // turn the left half plane by pi first
        if (z32[31] != z32[30]) begin
            z32 = z32 - 32'h8000_0000;
            x   = -x;
        end
        z = longint'($signed(z32));
        for (int i = 0; i < upi_pkg::CORDIC_STEPS_DEF && i < upi_pkg::TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(upi_pkg::ATAN_TABLE[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(upi_pkg::ATAN_TABLE[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic logic at_goal();
        longint      dx;
        longint      dy;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] r;
        dx = longint'(goal_x_q) - longint'(pose_x);
        dy = longint'(goal_y_q) - longint'(pose_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        r  = {33'd0, radius_q};
        if (ax > r || ay > r)
            return 1'b0;
        return (ax * ax + ay * ay) <= r * r;
    endfunction

    function automatic t_pose_result advance_pose(t_motion_cmd cmd);
        longint       dt;
        longint       rw;
        longint       travel;
        longint       turn;
        longint       half;
        longint       c;
        longint       s;
        t_pose_result res;
        if (cmd.action == ACT_SET_POSE) begin
            n_set_poses++;
            pose_x       = cmd.x;
            pose_y       = cmd.y;
            pose_heading = cmd.heading;
        end else begin
            n_ticks++;
            dt     = longint'(step_time_q);
            travel = (longint'(cmd.speed) * dt + 64'sd32768) >>> 16;
            rw     = longint'(cmd.rate) * dt;
            turn   = (rw + 64'sd32768) >>> 16;
            half   = (rw + 64'sd65536) >>> 17;
            rotate_unit(pose_heading + half[15:0], c, s);
            pose_x       = clamp32(longint'(pose_x) + ((travel * c + Q30_HALF) >>> 30));
            pose_y       = clamp32(longint'(pose_y) + ((travel * s + Q30_HALF) >>> 30));
            pose_heading = pose_heading + turn[15:0];
        end
        res.x       = pose_x;
        res.y       = pose_y;
        res.heading = pose_heading;
        res.arrived = at_goal();
        return res;
    endfunction

    function automatic void note_config(logic [7:0] idx, logic [31:0] data);
        case (idx)
            upi_pkg::CFG_STEP_TIME:     step_time_q = data[15:0];
            upi_pkg::CFG_GOAL_X:        goal_x_q    = data;
            upi_pkg::CFG_GOAL_Y:        goal_y_q    = data;
            upi_pkg::CFG_ARRIVE_RADIUS: radius_q    = data[30:0];
            default: ;
        endcase
    endfunction

    function automatic t_motion_cmd tick_cmd(logic signed [31:0] speed,
                                             logic signed [15:0] rate);
        t_motion_cmd cmd;
        cmd.action  = ACT_TICK;
        cmd.speed   = speed;
        cmd.rate    = rate;
        cmd.x       = $urandom;
        cmd.y       = $urandom;
        cmd.heading = 16'($urandom);
        return cmd;
    endfunction

    function automatic t_motion_cmd pose_cmd(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [15:0] heading);
        t_motion_cmd cmd;
        cmd.action  = ACT_SET_POSE;
        cmd.speed   = $urandom;
        cmd.rate    = 16'($urandom);
        cmd.x       = x;
        cmd.y       = y;
        cmd.heading = heading;
        return cmd;
    endfunction

    function automatic logic signed [31:0] scatter();
        return $signed($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
    endfunction

    function automatic t_motion_cmd random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return pose_cmd(goal_x_q + scatter(), goal_y_q + scatter(), 16'($urandom));
        if (pick < 14)
            return pose_cmd($urandom, $urandom, 16'($urandom));
        if (pick < 30)
            return tick_cmd($urandom, 16'($urandom));
        return tick_cmd($signed($urandom_range(0, 20 * ONE_M)) - 10 * ONE_M, 16'($urandom));
    endfunction

    task automatic send_cmd(t_motion_cmd cmd);
        if (idling && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_action          <= cmd.action;
        i_linear_velocity <= cmd.speed;
        i_angular_rate    <= cmd.rate;
        i_new_x           <= cmd.x;
        i_new_y           <= cmd.y;
        i_new_heading     <= cmd.heading;
        do @(posedge i_clk); while (o_in_stall);
        pending_poses = {pending_poses, advance_pose(cmd)};
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_poses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        note_config(idx, data);
        i_cfg_valid <= 1'b0;
        n_cfg_writes++;
    endtask

    // hold off the output when asked, otherwise stall at random while idling is set
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (idling) begin
            i_out_stall <= ($urandom_range(0, 99) < 26);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pose_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_poses.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected item x=%0d y=%0d heading=%0d arrived=%0b",
                             $realtime, o_out_x, o_out_y, o_out_heading, o_arrived);
            end else begin
                want = pending_poses.pop_front();
                if (o_arrived)
                    n_arrived++;
                if (o_out_x !== want.x || o_out_y !== want.y ||
                    o_out_heading !== want.heading || o_arrived !== want.arrived) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: mismatch x=%0d/%0d y=%0d/%0d heading=%0d/%0d %s %0b/%0b",
                                 $realtime, o_out_x, want.x, o_out_y, want.y,
                                 o_out_heading, want.heading, "arrived",
                                 o_arrived, want.arrived);
                end
            end
        end
    end

    task automatic test_reset_pose();
        send_cmd(tick_cmd(0, 0));
        send_cmd(tick_cmd(ONE_M, 0));
    endtask

    task automatic test_set_pose_extremes();
        send_cmd(pose_cmd(POS_MAX, POS_MIN, ANG_MIN));
        send_cmd(pose_cmd(POS_MIN, POS_MAX, ANG_MAX));
    endtask

    task automatic test_saturation();
        send_cmd(pose_cmd(POS_MAX - ONE_M, 0, 0));
        send_cmd(tick_cmd(POS_MAX, 0));
        send_cmd(pose_cmd(POS_MIN + ONE_M, 0, ANG_MIN));
        send_cmd(tick_cmd(POS_MAX, 0));
        send_cmd(pose_cmd(0, POS_MAX - ONE_M, ANG_HALF_PI));
        send_cmd(tick_cmd(POS_MAX, 0));
        send_cmd(pose_cmd(0, POS_MIN + ONE_M, ANG_HALF_PI));
        send_cmd(tick_cmd(POS_MIN, 0));
    endtask

    task automatic test_heading_wrap();
        send_cmd(pose_cmd(0, 0, ANG_MAX));
        send_cmd(tick_cmd(0, ANG_MAX));
        send_cmd(pose_cmd(0, 0, ANG_MIN));
        send_cmd(tick_cmd(0, ANG_MIN));
    endtask

    task automatic test_step_time_extremes();
        write_reg(upi_pkg::CFG_STEP_TIME, 32'hABCD_0000);
        send_cmd(tick_cmd(POS_MAX, ANG_MAX));
        write_reg(upi_pkg::CFG_STEP_TIME, 32'h0000_FFFF);
        send_cmd(tick_cmd(POS_MIN, ANG_MIN));
        send_cmd(tick_cmd(ONE_M, ANG_HALF_PI));
        write_reg(upi_pkg::CFG_STEP_TIME, {16'h0000, STEP_RESET});
    endtask

    task automatic test_arrival_radius();
        write_reg(upi_pkg::CFG_GOAL_X, 5 * ONE_M);
        write_reg(upi_pkg::CFG_GOAL_Y, -3 * ONE_M);
        write_reg(upi_pkg::CFG_ARRIVE_RADIUS, 2 * ONE_M);
        send_cmd(pose_cmd(7 * ONE_M, -3 * ONE_M, 0));
        send_cmd(pose_cmd(7 * ONE_M, -3 * ONE_M + 1, 0));
        write_reg(upi_pkg::CFG_ARRIVE_RADIUS, 32'hFFFF_FFFF);
        write_reg(upi_pkg::CFG_GOAL_X, POS_MAX);
        write_reg(upi_pkg::CFG_GOAL_Y, POS_MAX);
        send_cmd(pose_cmd(POS_MIN, POS_MAX, 0));
        send_cmd(pose_cmd(POS_MAX, POS_MAX, 0));
        send_cmd(tick_cmd(0, 0));
    endtask

    task automatic test_spare_registers();
        write_reg(CFG_SPARE_FIRST, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_LAST, 32'h0000_0000);
        write_reg(upi_pkg::CFG_GOAL_X, 0);
        write_reg(upi_pkg::CFG_GOAL_Y, 0);
        write_reg(upi_pkg::CFG_ARRIVE_RADIUS, 0);
        send_cmd(tick_cmd(ONE_M, ANG_HALF_PI));
    endtask

    // hold the output for a long stretch so the block fills up and stalls its input
    task automatic test_output_hold_off();
        drain_results();
        hold_request = 400;
        for (int k = 0; k < 12; k++)
            send_cmd(tick_cmd($signed($urandom_range(0, 20 * ONE_M)) - 10 * ONE_M,
                              16'($urandom)));
        drain_results();
    endtask

    task automatic test_steady_stream();
        drain_results();
        idling = 1'b0;
        for (int k = 0; k < 150; k++)
            send_cmd(random_cmd());
        drain_results();
        idling = 1'b1;
    endtask

    task automatic test_random_motion();
        logic [15:0] step;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       step = STEP_RESET;
                1:       step = 16'hFFFF;
                2:       step = 16'd1;
                3:       step = 16'd0;
                default: step = 16'($urandom);
            endcase
            write_reg(upi_pkg::CFG_STEP_TIME, ($urandom & 32'hFFFF_0000) | step);
            write_reg(upi_pkg::CFG_GOAL_X, (p == 6) ? POS_MAX : $urandom);
            write_reg(upi_pkg::CFG_GOAL_Y, (p == 6) ? POS_MIN : $urandom);
            write_reg(upi_pkg::CFG_ARRIVE_RADIUS,
                      (p == 7) ? 32'hFFFF_FFFF : $urandom_range(0, 24 * ONE_M));
            if (p == 4)
                write_reg(CFG_SPARE_FIRST + 8'($urandom_range(0, 251)), $urandom);
            for (int k = 0; k < 130; k++)
                send_cmd(random_cmd());
        end
        drain_results();
    endtask

    initial begin
        step_time_q  = STEP_RESET;
        goal_x_q     = '0;
        goal_y_q     = '0;
        radius_q     = '0;
        pose_x       = '0;
        pose_y       = '0;
        pose_heading = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pose();
        test_set_pose_extremes();
        test_saturation();
        test_heading_wrap();
        test_step_time_extremes();
        test_arrival_radius();
        test_spare_registers();
        test_output_hold_off();
        test_steady_stream();
        test_random_motion();

        drain_results();
        repeat (TICK_LATENCY + 13) @(posedge i_clk);
        failures += pending_poses.size();
        $display("Run covered %0d ticks and %0d pose loads; %0d results checked, %0d at the goal.",
                 n_ticks, n_set_poses, n_results, n_arrived);
        $display("%0d position clamps predicted, %0d register writes incl. unused indexes.",
                 n_clamped, n_cfg_writes);
        if (failures == 0)
            $display("** unicycle_pose_integrator: PASSED **");
        else
            $display("** unicycle_pose_integrator: FAILED **");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Run timed out with %0d items outstanding.", pending_poses.size());
        $display("** unicycle_pose_integrator: FAILED **");
        $finish;
    end

endmodule
